>>> rtl/core/dnsa_pkg.sv
// Shared types and constants for the DNS response A-record parser.
// No dependencies; used by every module under rtl/core.
package dnsa_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ipv4_address;
  } out_word_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_FOUND = 2'd0;
  localparam status_t ST_NONE  = 2'd1;
  localparam status_t ST_RCODE = 2'd2;
  localparam status_t ST_BAD   = 2'd3;

  typedef enum logic [9:0] {
    PH_HEADER = 10'b0000000001,
    PH_QNAME  = 10'b0000000010,
    PH_QPTR   = 10'b0000000100,
    PH_QFIXED = 10'b0000001000,
    PH_ANAME  = 10'b0000010000,
    PH_APTR   = 10'b0000100000,
    PH_AFIXED = 10'b0001000000,
    PH_RDATA  = 10'b0010000000,
    PH_TRAIL  = 10'b0100000000,
    PH_DONE   = 10'b1000000000
  } phase_t;

  localparam logic [7:0]  RCODE_MASK     = 8'h0F;
  localparam logic [7:0]  PTR_MASK       = 8'hC0;
  localparam logic [3:0]  HDR_LAST_BYTE  = 4'd11;
  localparam logic [3:0]  AFIX_LAST_BYTE = 4'd9;
  localparam logic [3:0]  QFIX_LAST_BYTE = 4'd3;
  localparam logic [15:0] RR_TYPE_A      = 16'd1;
  localparam logic [15:0] RDLEN_A        = 16'd4;

endpackage

>>> rtl/core/dns_response_a_record_parser.sv
// DNS response A-record parser, top level.
// The result word is registered in the output register when the parser consumes the last byte.
// Throughput: one byte per cycle; the input register stalls only while a
// finished result is held and the next message's last byte is waiting.
// Reset (synchronous, high) drops held words and returns parsing to the header.
// Depends on dnsa_pkg, dnsa_in_reg, dnsa_parser, dnsa_out_reg.
module dns_response_a_record_parser #(
  parameter int NAME_BUFFER = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  dnsa_pkg::in_word_t  data_word,
  output logic                result_valid,
  input  logic                result_stall,
  output dnsa_pkg::out_word_t result_word
);

  logic                held_valid;
  dnsa_pkg::in_word_t  held_word;
  logic                step;
  logic                out_busy;
  logic                res_load;
  dnsa_pkg::out_word_t res_word;

  assign step = held_valid && !(held_word.last_byte && out_busy);

  dnsa_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .valid      (data_valid),
    .word       (data_word),
    .consume    (step),
    .stall      (data_stall),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  dnsa_parser #(
    .NAME_BUFFER (NAME_BUFFER)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .word        (held_word),
    .result_load (res_load),
    .result_word (res_word)
  );

  dnsa_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_word (res_word),
    .stall     (result_stall),
    .valid     (result_valid),
    .word      (result_word),
    .busy      (out_busy)
  );

endmodule

>>> rtl/core/dnsa_in_reg.sv
// Input word register for the DNS A-record parser.
// Depends on dnsa_pkg; refills whenever the held word is consumed.
module dnsa_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  input  dnsa_pkg::in_word_t word,
  input  logic             consume,
  output logic             stall,
  output logic             held_valid,
  output dnsa_pkg::in_word_t held_word
);

  assign stall = held_valid && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!stall) begin
      held_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && !stall) begin
      held_word <= word;
    end
  end

endmodule

>>> rtl/core/dnsa_parser.sv
// Parse state and per-word step logic of the DNS A-record parser.
// Depends on dnsa_pkg; emits one result word on each message's last byte.
module dnsa_parser #(
  parameter int NAME_BUFFER = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  dnsa_pkg::in_word_t word,
  output logic               result_load,
  output dnsa_pkg::out_word_t result_word
);

  localparam int LEN_W = $clog2(NAME_BUFFER);
  localparam int SUM_W = $clog2(NAME_BUFFER + 256);
  localparam logic [SUM_W-1:0] NB_LIMIT    = SUM_W'(NAME_BUFFER);
  localparam logic [SUM_W-1:0] NB_DOT_STOP = SUM_W'(NAME_BUFFER - 1);

  dnsa_pkg::phase_t  phase, phase_next;
  logic [3:0]        fcb, fcb_next;
  logic [15:0]       q_left, q_left_next;
  logic [15:0]       a_left, a_left_next;
  logic [7:0]        lbl_left, lbl_left_next;
  logic [LEN_W-1:0]  name_len, name_len_next;
  logic [15:0]       rr_type, rr_type_next;
  logic [15:0]       rd_left, rd_left_next;
  logic [31:0]       addr, addr_next;
  dnsa_pkg::status_t outcome, outcome_next;

  logic [7:0]        b;
  logic [SUM_W-1:0]  len_dot;
  logic [SUM_W-1:0]  len_sum;
  logic [15:0]       a_dec;
  dnsa_pkg::status_t final_status;

  assign b = word.data_byte;

  always_comb begin
    phase_next    = phase;
    fcb_next      = fcb;
    q_left_next   = q_left;
    a_left_next   = a_left;
    lbl_left_next = lbl_left;
    name_len_next = name_len;
    rr_type_next  = rr_type;
    rd_left_next  = rd_left;
    addr_next     = addr;
    outcome_next  = outcome;
    a_dec         = a_left - 16'd1;

    if ((name_len != '0) && (SUM_W'(name_len) < NB_DOT_STOP)) begin
      len_dot = SUM_W'(name_len) + SUM_W'(1);
    end else begin
      len_dot = SUM_W'(name_len);
    end
    len_sum = len_dot + SUM_W'(b);

    case (phase)
      dnsa_pkg::PH_HEADER: begin
        if (fcb == 4'd3 && (b & dnsa_pkg::RCODE_MASK) != 8'd0) begin
          outcome_next = dnsa_pkg::ST_RCODE;
        end
        if (fcb == 4'd4) q_left_next = {b, 8'd0};
        if (fcb == 4'd5) q_left_next = {q_left[15:8], b};
        if (fcb == 4'd6) a_left_next = {b, 8'd0};
        if (fcb == 4'd7) a_left_next = {a_left[15:8], b};
        if (fcb >= dnsa_pkg::HDR_LAST_BYTE) begin
          fcb_next = 4'd0;
          if (outcome_next == dnsa_pkg::ST_RCODE) begin
            phase_next = dnsa_pkg::PH_DONE;
          end else if (q_left_next != 16'd0) begin
            phase_next    = dnsa_pkg::PH_QNAME;
            lbl_left_next = 8'd0;
            name_len_next = '0;
          end else if (a_left_next != 16'd0) begin
            phase_next    = dnsa_pkg::PH_ANAME;
            lbl_left_next = 8'd0;
            name_len_next = '0;
          end else begin
            phase_next = dnsa_pkg::PH_TRAIL;
          end
        end else begin
          fcb_next = fcb + 4'd1;
        end
      end
      dnsa_pkg::PH_QNAME, dnsa_pkg::PH_ANAME: begin
        fcb_next = 4'd1;
        if (lbl_left != 8'd0) begin
          lbl_left_next = lbl_left - 8'd1;
        end else if ((b & dnsa_pkg::PTR_MASK) == dnsa_pkg::PTR_MASK) begin
          phase_next = (phase == dnsa_pkg::PH_QNAME) ? dnsa_pkg::PH_QPTR
                                                     : dnsa_pkg::PH_APTR;
        end else if (b == 8'd0) begin
          phase_next = (phase == dnsa_pkg::PH_QNAME) ? dnsa_pkg::PH_QFIXED
                                                     : dnsa_pkg::PH_AFIXED;
          fcb_next   = 4'd0;
        end else if (len_sum >= NB_LIMIT) begin
          name_len_next = LEN_W'(len_dot);
          outcome_next  = dnsa_pkg::ST_BAD;
          phase_next    = dnsa_pkg::PH_DONE;
        end else begin
          name_len_next = LEN_W'(len_sum);
          lbl_left_next = b;
        end
      end
      dnsa_pkg::PH_QPTR: begin
        phase_next = dnsa_pkg::PH_QFIXED;
        fcb_next   = 4'd0;
      end
      dnsa_pkg::PH_APTR: begin
        phase_next = dnsa_pkg::PH_AFIXED;
        fcb_next   = 4'd0;
      end
      dnsa_pkg::PH_QFIXED: begin
        if (fcb >= dnsa_pkg::QFIX_LAST_BYTE) begin
          q_left_next = q_left - 16'd1;
          if (q_left_next != 16'd0) begin
            phase_next    = dnsa_pkg::PH_QNAME;
            fcb_next      = 4'd0;
            lbl_left_next = 8'd0;
            name_len_next = '0;
          end else if (a_left != 16'd0) begin
            phase_next    = dnsa_pkg::PH_ANAME;
            fcb_next      = 4'd0;
            lbl_left_next = 8'd0;
            name_len_next = '0;
          end else begin
            phase_next = dnsa_pkg::PH_TRAIL;
          end
        end else begin
          fcb_next = fcb + 4'd1;
        end
      end
      dnsa_pkg::PH_AFIXED: begin
        if (fcb == 4'd0) rr_type_next = {b, 8'd0};
        if (fcb == 4'd1) rr_type_next = {rr_type[15:8], b};
        if (fcb == 4'd8) rd_left_next = {b, 8'd0};
        if (fcb == 4'd9) rd_left_next = {rd_left[15:8], b};
        if (fcb >= dnsa_pkg::AFIX_LAST_BYTE) begin
          fcb_next  = 4'd0;
          addr_next = 32'd0;
          if (rd_left_next == 16'd0) begin
            a_left_next = a_dec;
            if (q_left != 16'd0) begin
              phase_next    = dnsa_pkg::PH_QNAME;
              lbl_left_next = 8'd0;
              name_len_next = '0;
            end else if (a_dec != 16'd0) begin
              phase_next    = dnsa_pkg::PH_ANAME;
              lbl_left_next = 8'd0;
              name_len_next = '0;
            end else begin
              phase_next = dnsa_pkg::PH_TRAIL;
            end
          end else begin
            phase_next = dnsa_pkg::PH_RDATA;
          end
        end else begin
          fcb_next = fcb + 4'd1;
        end
      end
      dnsa_pkg::PH_RDATA: begin
        if (rr_type == dnsa_pkg::RR_TYPE_A && rd_left == dnsa_pkg::RDLEN_A) begin
          fcb_next = 4'd1;
        end
        if (fcb_next != 4'd0) begin
          addr_next = {addr[23:0], b};
        end
        rd_left_next = rd_left - 16'd1;
        if (rd_left_next == 16'd0) begin
          if (fcb_next != 4'd0) begin
            outcome_next = dnsa_pkg::ST_FOUND;
            phase_next   = dnsa_pkg::PH_DONE;
          end else begin
            a_left_next = a_dec;
            fcb_next    = 4'd0;
            if (q_left != 16'd0) begin
              phase_next    = dnsa_pkg::PH_QNAME;
              lbl_left_next = 8'd0;
              name_len_next = '0;
            end else if (a_dec != 16'd0) begin
              phase_next    = dnsa_pkg::PH_ANAME;
              lbl_left_next = 8'd0;
              name_len_next = '0;
            end else begin
              phase_next = dnsa_pkg::PH_TRAIL;
            end
          end
        end
      end
      default: begin
      end
    endcase

    case (phase_next)
      dnsa_pkg::PH_HEADER, dnsa_pkg::PH_QPTR,
      dnsa_pkg::PH_APTR, dnsa_pkg::PH_AFIXED: begin
        final_status = dnsa_pkg::ST_BAD;
      end
      dnsa_pkg::PH_QNAME: begin
        final_status = (lbl_left_next != 8'd0) ? dnsa_pkg::ST_BAD : outcome_next;
      end
      dnsa_pkg::PH_ANAME: begin
        final_status = (fcb_next != 4'd0) ? dnsa_pkg::ST_BAD : outcome_next;
      end
      default: begin
        final_status = outcome_next;
      end
    endcase
  end

  assign result_load              = step && word.last_byte;
  assign result_word.status       = final_status;
  assign result_word.ipv4_address = (final_status == dnsa_pkg::ST_FOUND) ? addr_next : 32'd0;

  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      phase    <= dnsa_pkg::PH_HEADER;
      fcb      <= 4'd0;
      q_left   <= 16'd0;
      a_left   <= 16'd0;
      lbl_left <= 8'd0;
      name_len <= '0;
      rr_type  <= 16'd0;
      rd_left  <= 16'd0;
      addr     <= 32'd0;
      outcome  <= dnsa_pkg::ST_NONE;
    end else if (step) begin
      phase    <= phase_next;
      fcb      <= fcb_next;
      q_left   <= q_left_next;
      a_left   <= a_left_next;
      lbl_left <= lbl_left_next;
      name_len <= name_len_next;
      rr_type  <= rr_type_next;
      rd_left  <= rd_left_next;
      addr     <= addr_next;
      outcome  <= outcome_next;
    end
  end

endmodule

>>> rtl/core/dnsa_out_reg.sv
// Result register for the DNS A-record parser.
// Depends on dnsa_pkg; holds a result word until the consumer takes it.
module dnsa_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dnsa_pkg::out_word_t load_word,
  input  logic                stall,
  output logic                valid,
  output dnsa_pkg::out_word_t word,
  output logic                busy
);

  assign busy = valid && stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end
  end

endmodule

>>> rtl/core/dnsa_checker.sv
// Port-level checks for the DNS A-record parser, bound to the top level.
// Depends on dnsa_pkg and dns_response_a_record_parser.
module dnsa_checker (
  input logic                clk,
  input logic                rst,
  input logic                data_valid,
  input logic                data_stall,
  input dnsa_pkg::in_word_t  data_word,
  input logic                result_valid,
  input logic                result_stall,
  input dnsa_pkg::out_word_t result_word
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !data_stall)
    else $error("outputs not idle after reset");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !(result_valid && result_stall) |-> !data_stall)
    else $error("input stalled without result backpressure");

  a_addr_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status != dnsa_pkg::ST_FOUND
      |-> result_word.ipv4_address == 32'd0)
    else $error("address nonzero for status other than found");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_word))
    else $error("stalled result changed");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    data_valid && data_stall |=> data_valid && $stable(data_word))
    else $error("stalled input word changed");

endmodule

bind dns_response_a_record_parser dnsa_checker u_dnsa_checker (
  .clk          (clk),
  .rst          (rst),
  .data_valid   (data_valid),
  .data_stall   (data_stall),
  .data_word    (data_word),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word)
);
